[hdl/assert_macros.svh]
// Assertion macros used by the replacement unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/arc_pkg.sv]
// Shared constants and types of the ARC replacement unit.
package arc_pkg;
  localparam int MAX_ENTRIES_DEF = 4096;
  localparam int P_FRAC_BITS_DEF = 16;
  localparam int ENTRY_W = 12;
  localparam int CAP_W = 12;
  localparam int LIMIT_W = 13;
  localparam int LIST_W = 3;
  localparam int CAP_RESET = 1024;
  localparam int LIMIT_RESET = 1024;
  localparam int NUM_LISTS = 5;
  localparam int NUM_SLOTS = 4;

  typedef logic [LIST_W-1:0] list_code_t;

  localparam list_code_t LIST_NEW  = 3'd0;
  localparam list_code_t LIST_T1   = 3'd1;
  localparam list_code_t LIST_B1   = 3'd2;
  localparam list_code_t LIST_T2   = 3'd3;
  localparam list_code_t LIST_B2   = 3'd4;
  localparam list_code_t LIST_DEL  = 3'd5;
  localparam list_code_t LIST_GONE = 3'd6;

  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_B2_LIMIT = 1'b1;

  // one planned list move
  typedef struct packed {
    logic       vld;
    logic       from_head;
    list_code_t src;
    list_code_t dst;
    logic       emit;
  } move_t;
endpackage

[hdl/arc_cache_replacement_unit.sv]
// ARC replacement unit: top level with list sequencer, link and tag memories.
//
// Requests arrive on item_valid/item_stall (req_type, entry_id); each emitted
// list move comes out on result_valid/result_stall with last_move on the final
// move of a request. Configuration writes (cfg_index 0 capacity, 1 B2 limit)
// are always taken (cfg_ready high) and must only be issued while idle.
// After reset the tag memory is swept to "new", one entry per cycle, over
// all MAX_ENTRIES entries; item_stall stays high meanwhile.
// One request is worked on at a time: the tag read and its decode, then
// planning, then each list move as a link-memory read-modify-write (single
// read port) unless it is skipped, and the wrap-up; a ghost hit adds a
// serial divide and target update before planning. A dropped remove
// returns to idle straight after the tag read.
// Results pass through a pending register into an output register; a
// stalled receiver holds the result there and the sequencer waits only when
// both registers hold a result and another result is ready.
// A request with an entry_id at or above MAX_ENTRIES is dropped.
`include "assert_macros.svh"

module arc_cache_replacement_unit #(
  parameter int MAX_ENTRIES = arc_pkg::MAX_ENTRIES_DEF,
  parameter int P_FRAC_BITS = arc_pkg::P_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         req_type,
  input  logic [arc_pkg::ENTRY_W-1:0]  entry_id,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [arc_pkg::ENTRY_W-1:0]  moved_entry,
  output arc_pkg::list_code_t          from_list,
  output arc_pkg::list_code_t          to_list,
  output logic                         release_data,
  output logic                         last_move,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [arc_pkg::LIMIT_W-1:0]  cfg_data
);
  import arc_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int QW = CW + P_FRAC_BITS;
  localparam int PW = CAP_W + P_FRAC_BITS;
  localparam int DW = ((QW > PW) ? QW : PW) + 1;
  localparam int LW = 2 * AW;
  localparam int IX_T1 = 0;
  localparam int IX_B1 = 1;
  localparam int IX_T2 = 2;
  localparam int IX_B2 = 3;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'h0001,
    S_IDLE   = 15'h0002,
    S_TAG    = 15'h0004,
    S_DIV    = 15'h0008,
    S_PUPD   = 15'h0010,
    S_PLAN   = 15'h0020,
    S_MSTART = 15'h0040,
    S_U_GET  = 15'h0080,
    S_U_PW   = 15'h0100,
    S_U_NW   = 15'h0200,
    S_APPEND = 15'h0400,
    S_A_WR   = 15'h0800,
    S_A_WR2  = 15'h1000,
    S_EMIT   = 15'h2000,
    S_DONE   = 15'h4000
  } state_t;

  state_t         state;
  logic [AW-1:0]  clr_cnt;
  logic [CAP_W-1:0]   cap;
  logic [LIMIT_W-1:0] lim;
  logic [PW-1:0]  p_q;
  logic [CW-1:0]  cnt_q  [NUM_LISTS];
  logic [AW-1:0]  head_q [NUM_LISTS];
  logic [AW-1:0]  tail_q [NUM_LISTS];
  move_t          slots  [NUM_SLOTS];
  move_t          plan   [NUM_SLOTS];
  logic [2:0]     idx;
  logic           req_q;
  logic [AW-1:0]  e_q;
  list_code_t     tag_q;
  logic [AW-1:0]  cur_x;
  list_code_t     cur_s;
  list_code_t     cur_d;
  logic           cur_emit;
  logic [AW-1:0]  pe_q;
  logic [AW-1:0]  ne_q;
  logic           need_n;
  logic           pend_vld;
  logic [AW-1:0]  pend_x;
  list_code_t     pend_s;
  list_code_t     pend_d;

  logic           tag_we;
  logic [AW-1:0]  tag_waddr;
  list_code_t     tag_wdata;
  list_code_t     tag_rdata;
  logic           link_we;
  logic [AW-1:0]  link_waddr;
  logic [LW-1:0]  link_wdata;
  logic [AW-1:0]  link_raddr;
  logic [LW-1:0]  link_rdata;
  logic [AW-1:0]  lk_pe;
  logic [AW-1:0]  lk_ne;

  logic           div_start;
  logic           div_done;
  logic [QW-1:0]  div_num;
  logic [CW-1:0]  div_den;
  logic [QW-1:0]  div_quot;

  move_t          mv;
  logic [AW-1:0]  mv_x;
  list_code_t     li_code;
  logic [2:0]     lidx;
  logic [CW-1:0]  cnt_li;
  logic [AW-1:0]  head_li;
  logic [AW-1:0]  tail_li;
  logic           hd_hit;
  logic           tl_hit;
  logic           out_free;
  logic           out_load;
  logic           id_ok;

  logic [31:0]    c32, t1c, b1c, t2c, b2c, nl1, nall, pint, p1;
  logic           rep_t1;
  move_t          rep_mv;
  logic [CW-1:0]  r_num;
  logic [CW-1:0]  r_den;
  logic [DW-1:0]  d_val;
  logic [DW-1:0]  p_sum;
  logic [DW-1:0]  cfix;
  logic [PW-1:0]  p_next;

  arc_ram #(.W(LIST_W), .D(MAX_ENTRIES)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(AW'(entry_id)), .rdata(tag_rdata)
  );

  arc_ram #(.W(LW), .D(MAX_ENTRIES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  arc_div #(.NW(QW), .DW(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = pend_vld && out_free && (state == S_EMIT || state == S_DONE);
  assign id_ok      = {20'd0, entry_id} < 32'(MAX_ENTRIES);
  assign lk_pe      = link_rdata[LW-1:AW];
  assign lk_ne      = link_rdata[AW-1:0];

  assign mv = slots[idx[1:0]];

  always_comb begin
    if (state == S_MSTART) begin
      li_code = mv.src;
    end else if (state == S_APPEND || state == S_A_WR || state == S_A_WR2) begin
      li_code = cur_d;
    end else begin
      li_code = cur_s;
    end
  end

  assign lidx    = (li_code == LIST_NEW || li_code > LIST_DEL) ? 3'd0 : li_code - 3'd1;
  assign cnt_li  = cnt_q[lidx];
  assign head_li = head_q[lidx];
  assign tail_li = tail_q[lidx];
  assign mv_x    = mv.from_head ? head_li : e_q;
  assign hd_hit  = (head_li == cur_x);
  assign tl_hit  = (tail_li == cur_x);

  // replacement choice and ARC sizing terms
  assign c32  = 32'(cap);
  assign t1c  = 32'(cnt_q[IX_T1]);
  assign b1c  = 32'(cnt_q[IX_B1]);
  assign t2c  = 32'(cnt_q[IX_T2]);
  assign b2c  = 32'(cnt_q[IX_B2]);
  assign nl1  = t1c + b1c;
  assign nall = nl1 + t2c + b2c;
  assign pint = 32'(p_q[PW-1:P_FRAC_BITS]);
  assign p1   = (pint == 32'd0) ? 32'd1 : pint;
  assign rep_t1 = (tag_q == LIST_B2) ? (t1c >= p1) : (t1c > pint);
  assign rep_mv = '{vld: 1'b1, from_head: 1'b1,
                    src: rep_t1 ? LIST_T1 : LIST_T2,
                    dst: rep_t1 ? LIST_B1 : LIST_B2, emit: 1'b1};

  // target update on a ghost hit
  assign r_num  = (tag_q == LIST_B1) ? cnt_q[IX_B2] : cnt_q[IX_B1];
  assign r_den  = (tag_q == LIST_B1) ? cnt_q[IX_B1] : cnt_q[IX_B2];
  assign d_val  = (r_num > r_den) ? DW'(div_quot) : (DW'(1) << P_FRAC_BITS);
  assign cfix   = DW'({cap, {P_FRAC_BITS{1'b0}}});
  assign p_sum  = DW'(p_q) + d_val;

  always_comb begin
    if (tag_q == LIST_B1) begin
      p_next = (r_den == '0 || p_sum > cfix) ? PW'(cfix) : PW'(p_sum);
    end else begin
      p_next = (r_den == '0 || DW'(p_q) < d_val) ? '0 : PW'(DW'(p_q) - d_val);
    end
  end

  always_comb begin
    div_start = (state == S_TAG) && (req_q == REQ_ACCESS) &&
                (tag_rdata == LIST_B1 || tag_rdata == LIST_B2);
    div_num   = (tag_rdata == LIST_B1) ? {cnt_q[IX_B2], {P_FRAC_BITS{1'b0}}}
                                       : {cnt_q[IX_B1], {P_FRAC_BITS{1'b0}}};
    div_den   = (tag_rdata == LIST_B1) ? cnt_q[IX_B1] : cnt_q[IX_B2];
  end

  always_comb begin
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      plan[i] = '0;
    end
    if (req_q == REQ_REMOVE) begin
      plan[0] = '{vld: 1'b1, from_head: 1'b0, src: tag_q, dst: LIST_GONE, emit: 1'b1};
    end else if (tag_q == LIST_T1 || tag_q == LIST_T2) begin
      plan[0] = '{vld: 1'b1, from_head: 1'b0, src: tag_q, dst: LIST_T2,
                  emit: (tag_q == LIST_T1)};
    end else if (tag_q == LIST_B1 || tag_q == LIST_B2) begin
      plan[0] = rep_mv;
      plan[1] = '{vld: 1'b1, from_head: 1'b0, src: tag_q, dst: LIST_T2, emit: 1'b1};
    end else begin
      if (tag_q == LIST_DEL) begin
        plan[2'(n)] = '{vld: 1'b1, from_head: 1'b0, src: LIST_DEL, dst: LIST_GONE,
                        emit: 1'b0};
        n = n + 1;
      end
      if (nl1 == c32) begin
        if (t1c < c32) begin
          plan[2'(n)] = '{vld: 1'b1, from_head: 1'b1, src: LIST_B1, dst: LIST_DEL,
                          emit: 1'b1};
          n = n + 1;
          plan[2'(n)] = rep_mv;
          n = n + 1;
        end else begin
          plan[2'(n)] = '{vld: 1'b1, from_head: 1'b1, src: LIST_T1, dst: LIST_DEL,
                          emit: 1'b1};
          n = n + 1;
        end
      end else if (nall >= c32) begin
        if (b2c >= 32'(lim) && nall >= (c32 << 1)) begin
          plan[2'(n)] = '{vld: 1'b1, from_head: 1'b1, src: LIST_B2, dst: LIST_DEL,
                          emit: 1'b1};
          n = n + 1;
        end
        plan[2'(n)] = rep_mv;
        n = n + 1;
      end
      plan[2'(n)] = '{vld: 1'b1, from_head: 1'b0, src: LIST_NEW, dst: LIST_T1, emit: 1'b1};
    end
  end

  // memory ports
  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = cur_x;
    tag_wdata  = (cur_d == LIST_GONE) ? LIST_NEW : cur_d;
    link_we    = 1'b0;
    link_waddr = cur_x;
    link_wdata = '0;
    link_raddr = cur_x;
    unique case (state)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_cnt;
        tag_wdata = LIST_NEW;
      end
      S_MSTART: begin
        link_raddr = mv_x;
      end
      S_U_GET: begin
        link_raddr = hd_hit ? lk_ne : lk_pe;
      end
      S_U_PW: begin
        link_we    = 1'b1;
        link_waddr = pe_q;
        link_wdata = {lk_pe, ne_q};
        link_raddr = ne_q;
      end
      S_U_NW: begin
        link_we    = 1'b1;
        link_waddr = ne_q;
        link_wdata = {pe_q, lk_ne};
      end
      S_APPEND: begin
        tag_we     = 1'b1;
        link_raddr = tail_li;
        link_we    = (cur_d != LIST_GONE) && (cnt_li == '0);
      end
      S_A_WR: begin
        link_we    = 1'b1;
        link_waddr = tail_li;
        link_wdata = {lk_pe, cur_x};
      end
      S_A_WR2: begin
        link_we    = 1'b1;
        link_wdata = {tail_li, AW'(0)};
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
      moved_entry  <= ENTRY_W'(pend_x);
      from_list    <= pend_s;
      to_list      <= pend_d;
      release_data <= (pend_s == LIST_T1 && pend_d == LIST_B1) ||
                      (pend_s == LIST_T2 && pend_d == LIST_B2);
      last_move    <= (state == S_DONE);
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      cap          <= CAP_W'(CAP_RESET);
      lim          <= LIMIT_W'(LIMIT_RESET);
      p_q          <= '0;
      pend_vld     <= 1'b0;
      idx          <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAPACITY) begin
          cap <= cfg_data[CAP_W-1:0];
        end else begin
          lim <= cfg_data;
        end
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid && id_ok) begin
            req_q <= req_type;
            e_q   <= AW'(entry_id);
            state <= S_TAG;
          end
        end
        S_TAG: begin
          tag_q <= tag_rdata;
          if (req_q == REQ_REMOVE) begin
            state <= (tag_rdata >= LIST_T1 && tag_rdata <= LIST_DEL) ? S_PLAN : S_IDLE;
          end else if (tag_rdata == LIST_B1 || tag_rdata == LIST_B2) begin
            state <= S_DIV;
          end else begin
            state <= S_PLAN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_PUPD;
          end
        end
        S_PUPD: begin
          p_q   <= p_next;
          state <= S_PLAN;
        end
        S_PLAN: begin
          slots <= plan;
          idx   <= '0;
          state <= S_MSTART;
        end
        S_MSTART: begin
          if (idx == 3'(NUM_SLOTS) || !mv.vld) begin
            state <= S_DONE;
          end else if (mv.from_head && cnt_li == '0) begin
            idx <= idx + 1'b1;
          end else begin
            cur_x    <= mv_x;
            cur_s    <= mv.src;
            cur_d    <= mv.dst;
            cur_emit <= mv.emit;
            state    <= (mv.src == LIST_NEW || cnt_li == '0) ? S_APPEND : S_U_GET;
          end
        end
        S_U_GET: begin
          pe_q   <= lk_pe;
          ne_q   <= lk_ne;
          need_n <= !tl_hit;
          if (hd_hit) begin
            head_q[lidx] <= lk_ne;
          end
          if (tl_hit) begin
            tail_q[lidx] <= lk_pe;
          end
          cnt_q[lidx] <= cnt_li - 1'b1;
          if (!hd_hit) begin
            state <= S_U_PW;
          end else if (!tl_hit) begin
            state <= S_U_NW;
          end else begin
            state <= S_APPEND;
          end
        end
        S_U_PW: begin
          state <= need_n ? S_U_NW : S_APPEND;
        end
        S_U_NW: begin
          state <= S_APPEND;
        end
        S_APPEND: begin
          if (cur_d == LIST_GONE || cnt_li == '0) begin
            if (cur_d != LIST_GONE) begin
              head_q[lidx] <= cur_x;
              tail_q[lidx] <= cur_x;
              cnt_q[lidx]  <= CW'(1);
            end
            state <= cur_emit ? S_EMIT : S_MSTART;
            if (!cur_emit) begin
              idx <= idx + 1'b1;
            end
          end else begin
            state <= S_A_WR;
          end
        end
        S_A_WR: begin
          state <= S_A_WR2;
        end
        S_A_WR2: begin
          tail_q[lidx] <= cur_x;
          cnt_q[lidx]  <= cnt_li + 1'b1;
          state <= cur_emit ? S_EMIT : S_MSTART;
          if (!cur_emit) begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (!pend_vld || out_free) begin
            pend_vld <= 1'b1;
            pend_x   <= cur_x;
            pend_s   <= cur_s;
            pend_d   <= cur_d;
            idx      <= idx + 1'b1;
            state    <= S_MSTART;
          end
        end
        S_DONE: begin
          if (!pend_vld) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_vld     <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_clear_once, clk, rst, state != S_CLEAR, state != S_CLEAR, "clear pass restarted")
  `ASSERT_SAME(a_div_state, clk, rst, div_done, state == S_DIV, "divider done outside wait")
  `ASSERT_SAME(a_no_underflow, clk, rst, state == S_U_GET, cnt_li != '0, "list count underflow")
  `ASSERT_NEXT(a_emit_hold, clk, rst, state == S_EMIT && pend_vld && result_valid && result_stall, state == S_EMIT, "pending result overwritten")
endmodule

[hdl/arc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module arc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/arc_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module arc_div #(
  parameter int NW = 29,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW:0]     rem;
  logic [DW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            ge;

  assign rem_sh  = {rem[DW-1:0], quot[NW-1]};
  assign ge      = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= den;
      quot <= num;
    end else if (busy) begin
      rem  <= ge ? rem_sub : rem_sh;
      quot <= {quot[NW-2:0], ge};
    end
  end
endmodule

[test/arc_cache_replacement_unit_tb.sv]
// Self-checking testbench of the ARC replacement unit: predicted list moves vs. DUT results.
module arc_cache_replacement_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arc_pkg::*;

  localparam int NSLOT = 4096;
  localparam int PFB = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic rt;
    logic [ENTRY_W-1:0] id;
  } req_t;

  typedef struct {
    logic [ENTRY_W-1:0] ent;
    list_code_t from_l;
    list_code_t to_l;
    logic rel;
    logic last;
  } move_rec_t;

  logic clk = 0, rst = 1;
  logic item_valid = 0, req_type = 0, result_stall = 0;
  logic [ENTRY_W-1:0] entry_id = '0;
  logic item_stall, result_valid, release_data, last_move, cfg_ready;
  logic [ENTRY_W-1:0] moved_entry;
  list_code_t from_list, to_list;
  logic cfg_valid = 0, cfg_index = CFG_CAPACITY;
  logic [LIMIT_W-1:0] cfg_data = '0;

  arc_cache_replacement_unit u_dut (.*);

  initial forever #5 clk = ~clk;

  // model state
  list_code_t tag_mem [NSLOT];
  logic [ENTRY_W-1:0] prv [NSLOT];
  logic [ENTRY_W-1:0] nxt [NSLOT];
  logic [ENTRY_W-1:0] head [5];
  logic [ENTRY_W-1:0] tail [5];
  int unsigned cnt [5];
  longint unsigned target_p;
  int unsigned capacity, b2_limit;

  req_t pending_reqs[$];
  move_rec_t expected_moves[$];
  bit item_taken, calm;
  int errors, n_items, n_moves, n_cfg, idle_cycles;

  function automatic void record_move(logic [ENTRY_W-1:0] e, list_code_t s, list_code_t d);
    move_rec_t m;
    m.ent = e; m.from_l = s; m.to_l = d; m.last = 1'b0;
    m.rel = (s == LIST_T1 && d == LIST_B1) || (s == LIST_T2 && d == LIST_B2);
    expected_moves.push_back(m);
  endfunction

  function automatic void list_unlink(logic [ENTRY_W-1:0] e);
    int l;
    l = int'(tag_mem[e]) - 1;
    if (l < 0 || l >= 5 || cnt[l] == 0) return;
    if (head[l] == e) head[l] = nxt[e];
    else nxt[prv[e]] = nxt[e];
    if (tail[l] == e) tail[l] = prv[e];
    else prv[nxt[e]] = prv[e];
    cnt[l]--;
  endfunction

  function automatic void list_append(logic [ENTRY_W-1:0] e, list_code_t t);
    int l;
    l = int'(t) - 1;
    tag_mem[e] = t;
    if (cnt[l] == 0) head[l] = e;
    else begin
      nxt[tail[l]] = e;
      prv[e] = tail[l];
    end
    tail[l] = e;
    cnt[l]++;
  endfunction

  function automatic void relink(logic [ENTRY_W-1:0] e, list_code_t d);
    list_code_t s;
    s = tag_mem[e];
    list_unlink(e);
    list_append(e, d);
    record_move(e, s, d);
  endfunction

  function automatic void evict_lru(list_code_t s, list_code_t d);
    if (cnt[s-1] == 0) return;
    relink(head[s-1], d);
  endfunction

  function automatic void pick_victim(bit from_b2);
    longint unsigned pint, p1, t1;
    pint = target_p >> PFB;
    p1 = (pint < 1) ? 1 : pint;
    t1 = cnt[LIST_T1-1];
    if (from_b2 ? (t1 >= p1) : (t1 > pint)) evict_lru(LIST_T1, LIST_B1);
    else evict_lru(LIST_T2, LIST_B2);
  endfunction

  function automatic void admit_new(logic [ENTRY_W-1:0] e);
    int unsigned nl1, nall;
    nl1 = cnt[LIST_T1-1] + cnt[LIST_B1-1];
    if (nl1 == capacity) begin
      if (cnt[LIST_T1-1] < capacity) begin
        evict_lru(LIST_B1, LIST_DEL);
        pick_victim(1'b0);
      end else evict_lru(LIST_T1, LIST_DEL);
    end else begin
      nall = nl1 + cnt[LIST_T2-1] + cnt[LIST_B2-1];
      if (nall >= capacity) begin
        if (cnt[LIST_B2-1] >= b2_limit && nall >= 2 * capacity) evict_lru(LIST_B2, LIST_DEL);
        pick_victim(1'b0);
      end
    end
    list_append(e, LIST_T1);
    record_move(e, LIST_NEW, LIST_T1);
  endfunction

  function automatic longint unsigned adapt_step(int unsigned num, int unsigned den,
                                                 output bit inf);
    inf = 1'b0;
    if (den == 0) begin
      inf = 1'b1;
      return 0;
    end
    if (num > den) return (longint'(num) << PFB) / den;
    return longint'(1) << PFB;
  endfunction

  function automatic void predict_moves(logic rt, logic [ENTRY_W-1:0] e);
    list_code_t t;
    longint unsigned d, cfix;
    bit inf;
    int n_prior;
    n_prior = expected_moves.size();
    t = tag_mem[e];
    cfix = longint'(capacity) << PFB;
    if (rt == REQ_REMOVE) begin
      if (t >= LIST_T1 && t <= LIST_DEL) begin
        list_unlink(e);
        tag_mem[e] = LIST_NEW;
        record_move(e, t, LIST_GONE);
      end
    end else if (t == LIST_T1) relink(e, LIST_T2);
    else if (t == LIST_T2) begin
      list_unlink(e);
      list_append(e, LIST_T2);
    end else if (t == LIST_B1) begin
      d = adapt_step(cnt[LIST_B2-1], cnt[LIST_B1-1], inf);
      target_p = (inf || target_p + d > cfix) ? cfix : target_p + d;
      pick_victim(1'b0);
      relink(e, LIST_T2);
    end else if (t == LIST_B2) begin
      d = adapt_step(cnt[LIST_B1-1], cnt[LIST_B2-1], inf);
      target_p = (inf || target_p < d) ? 0 : target_p - d;
      pick_victim(1'b1);
      relink(e, LIST_T2);
    end else begin
      if (t == LIST_DEL) begin
        list_unlink(e);
        tag_mem[e] = LIST_NEW;
      end
      admit_new(e);
    end
    if (expected_moves.size() > n_prior) expected_moves[$].last = 1'b1;
  endfunction

  // request driver
  always @(posedge clk) begin
    item_taken = item_valid && !item_stall && !rst;
    if (item_taken) begin
      predict_moves(req_type, entry_id);
      n_items++;
    end
  end

  always @(negedge clk) begin
    req_t r;
    if (!rst && (!item_valid || item_taken)) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        r = pending_reqs.pop_front();
        item_valid <= 1'b1;
        req_type <= r.rt;
        entry_id <= r.id;
      end else item_valid <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    move_rec_t m;
    if (!rst && result_valid && !result_stall) begin
      n_moves++;
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected transaction entry %0d %0d->%0d", $time,
                 moved_entry, from_list, to_list);
        errors++;
      end else begin
        m = expected_moves.pop_front();
        if (moved_entry !== m.ent || from_list !== m.from_l || to_list !== m.to_l ||
            release_data !== m.rel || last_move !== m.last) begin
          $display("%0t: mismatch exp ent=%0d from=%0d to=%0d rel=%0b last=%0b", $time,
                   m.ent, m.from_l, m.to_l, m.rel, m.last);
          $display("%0t:          got ent=%0d from=%0d to=%0d rel=%0b last=%0b", $time,
                   moved_entry, from_list, to_list, release_data, last_move);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) result_stall <= !calm && ($urandom_range(0, 99) < 6);

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("arc_cache_replacement_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic push_req(logic rt, int id);
    req_t r;
    r.rt = rt;
    r.id = ENTRY_W'(id);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || item_valid) @(posedge clk);
    while (expected_moves.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= LIMIT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CAPACITY) capacity = val & 12'hFFF;
    else b2_limit = val & 13'h1FFF;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int pool);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        push_req(1'($urandom_range(0, 1)), int'($urandom_range(0, NSLOT - 1)));
      else push_req($urandom_range(0, 99) < 15 ? REQ_REMOVE : REQ_ACCESS,
                    int'($urandom_range(0, pool)));
    end
  endtask

  initial begin
    int caps [5] = '{4, 1, 2048, 8, 16};
    int lims [5] = '{2, 0, 4096, 3, 16};
    for (int i = 0; i < NSLOT; i++) tag_mem[i] = LIST_NEW;
    for (int i = 0; i < 5; i++) begin
      head[i] = 0; tail[i] = 0; cnt[i] = 0;
    end
    target_p = 0;
    capacity = CAP_RESET;
    b2_limit = LIMIT_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // default registers: a few requests first
    push_req(REQ_ACCESS, 0);
    push_req(REQ_ACCESS, NSLOT - 1);
    push_req(REQ_ACCESS, 0);
    push_req(REQ_ACCESS, 0);
    push_req(REQ_REMOVE, NSLOT - 1);
    push_req(REQ_REMOVE, 5);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_CAPACITY, caps[ph]);
      write_reg(CFG_B2_LIMIT, lims[ph]);
      if (ph == 0) begin
        for (int i = 1; i <= 10; i++) push_req(REQ_ACCESS, i);
        push_req(REQ_ACCESS, 1);
        push_req(REQ_ACCESS, 9);
        push_req(REQ_ACCESS, 9);
        push_req(REQ_ACCESS, 2);
        push_req(REQ_ACCESS, 5);
        push_req(REQ_REMOVE, 3);
        push_req(REQ_REMOVE, 10);
        push_req(REQ_ACCESS, 1);
        drain();
      end
      calm = (ph == 3);
      random_phase(50, caps[ph] > 64 ? 63 : 4 * caps[ph] + 3);
      drain();
      calm = 1'b0;
    end
    $display("covered %0d requests, %0d list moves, %0d register writes over 5 settings",
             n_items, n_moves, n_cfg);
    if (errors == 0) $display("arc_cache_replacement_unit_tb: done, clean");
    else $display("arc_cache_replacement_unit_tb: done, errors");
    $finish;
  end
endmodule

[filelist.f]
+incdir+hdl
hdl/arc_pkg.sv
hdl/arc_ram.sv
hdl/arc_div.sv
hdl/arc_cache_replacement_unit.sv
test/arc_cache_replacement_unit_tb.sv
